FILE: rtl/sssb_pkg.sv
// Shared definitions for the sorted store with binary search:
// command and status codes, the controller state type and default sizes.
// No dependencies.
`default_nettype none

package sssb_pkg;

    localparam int unsigned DEPTH_DEFAULT = 256;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned POSITION_W = 8;
    localparam int unsigned HELD_W     = 9;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_APPENDED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_CMP
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/sorted_store_binary_search.sv
// Top level of the sorted store with binary search: value memory, entry
// count and the search controller in one module.
// Depends on sssb_pkg.
`default_nettype none

// The block holds up to DEPTH signed 32-bit values in a single-port
// synchronous memory plus an entry count. A command transfers at a rising
// edge where start is high and busy is low. An append writes the value at
// slot entry_count and reports that slot; with the store full the value is
// dropped and status says so. An append keeps busy low, so appends can
// follow each other in every cycle, and its result appears in the next
// cycle. A search runs a binary search over slots 0..count-1; each probe
// reads the memory at the midpoint, then compares and narrows the window.
// A search holds busy until its last compare, and its result follows in
// the next cycle. A search of an empty store answers in the next cycle like
// an append. Each result is on the output ports for exactly one cycle with
// o_valid high; the receiver cannot stall it, so sample it then. The memory
// is not cleared at reset: only slots below the count are ever read.
// position and entries_held are truncated to their port widths when DEPTH
// is larger.
module sorted_store_binary_search #(
    parameter int unsigned DEPTH = sssb_pkg::DEPTH_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_cmd,
    input  wire logic signed [sssb_pkg::VALUE_W-1:0] i_item_value,
    output logic                                    o_valid,
    output logic [1:0]                              o_status,
    output logic [sssb_pkg::POSITION_W-1:0]         o_position,
    output logic [sssb_pkg::HELD_W-1:0]             o_entries_held
);
    import sssb_pkg::*;

    // AW indexes the memory, CW holds the count up to DEPTH itself,
    // LW is signed with room for right = -1 and left = count.
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned LW = CW + 1;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic signed [LW-1:0]      r_lo, n_lo;
    logic signed [LW-1:0]      r_hi, n_hi;
    logic [AW-1:0]             r_mid, n_mid;
    logic signed [VALUE_W-1:0] r_key, n_key;
    logic                      r_valid, n_valid;
    t_status                   r_status, n_status;
    logic [POSITION_W-1:0]     r_pos, n_pos;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_append;
    logic signed [LW-1:0]      w_mid;
    logic signed [LW-1:0]      w_mid_ext;
    logic signed [LW-1:0]      w_lo_up;
    logic signed [LW-1:0]      w_hi_dn;
    logic                      w_eq;
    logic                      w_lt;
    logic                      w_exhausted;

    assign w_accept  = start && !busy;
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_append  = w_accept && (i_cmd == CMD_APPEND) && !w_full;

    // Midpoint of the current window; right >= left whenever it is used.
    assign w_mid     = r_lo + ((r_hi - r_lo) >>> 1);
    assign w_mid_ext = $signed(LW'(r_mid));
    assign w_lo_up   = w_mid_ext + LW'(1);
    assign w_hi_dn   = w_mid_ext - LW'(1);

    assign w_eq      = (r_rdata == r_key);
    assign w_lt      = (r_rdata < r_key);
    // Window empty after this probe narrows it.
    assign w_exhausted = w_lt ? (w_lo_up > r_hi) : (r_lo > w_hi_dn);

    // Memory: write on append, read at the midpoint while issuing a probe.
    // One command runs at a time, so a write always lands before any read.
    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_mem[r_count[AW-1:0]] <= i_item_value;
        end
        if (r_state == S_ISSUE) begin
            r_rdata <= r_mem[w_mid[AW-1:0]];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd == CMD_SEARCH) && (r_count != '0)) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_eq || w_exhausted) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and result register updates.
    always_comb begin
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_key    = r_key;
        n_valid  = 1'b0;
        n_status = r_status;
        n_pos    = r_pos;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_APPEND) begin
                        n_valid = 1'b1;
                        if (w_full) begin
                            n_status = ST_FULL;
                            n_pos    = '0;
                        end else begin
                            n_status = ST_APPENDED;
                            n_pos    = POSITION_W'(r_count);
                            n_count  = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_NOT_FOUND;
                        n_pos    = '0;
                    end else begin
                        n_key = i_item_value;
                        n_lo  = '0;
                        n_hi  = $signed(LW'(r_count)) - LW'(1);
                    end
                end
            end
            S_ISSUE: begin
                n_mid = w_mid[AW-1:0];
            end
            S_CMP: begin
                if (w_eq) begin
                    n_valid  = 1'b1;
                    n_status = ST_FOUND;
                    n_pos    = POSITION_W'(r_mid);
                end else begin
                    if (w_lt) begin
                        n_lo = w_lo_up;
                    end else begin
                        n_hi = w_hi_dn;
                    end
                    if (w_exhausted) begin
                        n_valid  = 1'b1;
                        n_status = ST_NOT_FOUND;
                        n_pos    = '0;
                    end
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_key    <= n_key;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    // Outputs.
    always_comb begin
        busy           = (r_state != S_IDLE);
        o_valid        = r_valid;
        o_status       = r_status;
        o_position     = r_pos;
        o_entries_held = HELD_W'(r_count);
    end

    // A result strobe is only raised as the controller returns to idle.
    a_valid_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE))
        else $error("result strobe while search still running");

    // The count never passes the store depth.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // A probe is only issued inside a non-empty window below the count.
    a_probe_window : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> ((r_lo <= r_hi) && (r_hi < $signed(LW'(r_count)))))
        else $error("probe outside the search window");

    // A found slot is one that has been written.
    a_found_written : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FOUND)) |-> (CW'(r_mid) < r_count))
        else $error("found position beyond stored entries");

    // Appends do not change the count while a search is running.
    a_count_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_count))
        else $error("entry count changed during search");

endmodule

`default_nettype wire

FILE: bench/sorted_store_binary_search_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_store_binary_search: a queue-fed command driver, a result
// monitor and a bit-accurate store/search predictor checked against every result strobe.
// Depends on sssb_pkg and sorted_store_binary_search.

module sorted_store_binary_search_test;

    import sssb_pkg::*;

    localparam int unsigned STORE_DEPTH = DEPTH_DEFAULT;
    localparam int          RANDOM_CMDS = 450;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One pending command and the idle cycles the driver inserts ahead of it.
    typedef struct {
        logic                      cmd;
        logic signed [VALUE_W-1:0] value;
        int                        gap;
    } t_store_cmd;

    // One predicted result strobe.
    typedef struct {
        t_status                 status;
        logic [POSITION_W-1:0]   position;
        logic [HELD_W-1:0]       held;
    } t_store_result;

    // Clock and reset. Every block input starts at a known value.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                      start        = 1'b0;
    logic                      i_cmd        = CMD_APPEND;
    logic signed [VALUE_W-1:0] i_item_value = '0;

    logic                      busy;
    logic                      o_valid;
    logic [1:0]                o_status;
    logic [POSITION_W-1:0]     o_position;
    logic [HELD_W-1:0]         o_entries_held;

    always #1 i_clk = ~i_clk;

    sorted_store_binary_search #(
        .DEPTH(STORE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_item_value  (i_item_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entries_held(o_entries_held)
    );

    // Stimulus and expectation queues.
    t_store_cmd    pending_cmds[$];
    t_store_result pending_results[$];

    // Predictor state: its own copy of the value store and the entry count.
    logic signed [VALUE_W-1:0] shadow_store[STORE_DEPTH];
    int unsigned               shadow_count;

    // Generator-side view of what has been appended, used to pick search keys.
    logic signed [VALUE_W-1:0] planned_vals[STORE_DEPTH];
    int unsigned               planned_count;
    logic signed [VALUE_W-1:0] planned_top;
    int                        burst_left;

    // Bookkeeping.
    int error_count;
    int n_appended;
    int n_dropped;
    int n_found;
    int n_missed;
    int gap_left;

    // Compute the result of one transferred command and advance the shadow store.
    task automatic predict_store_op(input logic cmd, input logic signed [VALUE_W-1:0] key);
        t_store_result             res;
        longint                    lo;
        longint                    hi;
        longint                    mid;
        logic signed [VALUE_W-1:0] probe;
        begin
            res.position = '0;
            if (cmd == CMD_APPEND) begin
                if (shadow_count < STORE_DEPTH) begin
                    shadow_store[shadow_count] = key;
                    res.position = POSITION_W'(shadow_count);
                    shadow_count++;
                    res.status = ST_APPENDED;
                end else begin
                    res.status = ST_FULL;
                end
            end else begin
                // Walk the same probe sequence as the block: stop on the first equal probe.
                res.status = ST_NOT_FOUND;
                lo = 0;
                hi = longint'(shadow_count) - 1;
                while (lo <= hi) begin
                    mid   = lo + (hi - lo) / 2;
                    probe = shadow_store[mid];
                    if (probe == key) begin
                        res.status   = ST_FOUND;
                        res.position = POSITION_W'(mid);
                        break;
                    end else if (probe < key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            res.held = HELD_W'(shadow_count);
            pending_results.push_back(res);
        end
    endtask

    // Queue one command; draw its leading gap and track appends for key selection.
    task automatic add_cmd(input logic cmd, input logic signed [VALUE_W-1:0] value);
        t_store_cmd item;
        begin
            item.cmd   = cmd;
            item.value = value;
            if (burst_left > 0) begin
                burst_left--;
                item.gap = 0;
            end else begin
                if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 24);
                item.gap = $urandom_range(0, 8);
            end
            if (cmd == CMD_APPEND && planned_count < STORE_DEPTH) begin
                planned_vals[planned_count] = value;
                planned_count++;
            end
            pending_cmds.push_back(item);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] VAL_VALUE(input longint v);
        return v[VALUE_W-1:0];
    endfunction

    // Next value to append: mostly an ascending walk that ends at the top of the range,
    // with duplicates and the odd out-of-order value mixed in.
    function automatic logic signed [VALUE_W-1:0] next_append_value();
        longint        span;
        longint        max_step;
        longint        step;
        logic [63:0]   raw;
        begin
            if (planned_count >= STORE_DEPTH - 1) begin
                planned_top = VAL_MAX;
                return VAL_MAX;
            end
            if ($urandom_range(0, 24) == 0) return $urandom();
            span     = longint'(VAL_MAX) - longint'(planned_top);
            max_step = (span * 2) / longint'(STORE_DEPTH - planned_count);
            if (max_step > span) max_step = span;
            raw  = {$urandom(), $urandom()};
            step = longint'(raw % 64'(max_step + 1));
            if ($urandom_range(0, 4) == 0) step = 0;
            planned_top = VAL_VALUE(longint'(planned_top) + step);
            return planned_top;
        end
    endfunction

    // Search key: a stored value, a neighbor of one, an extreme, zero or -1, or anything at all.
    function automatic logic signed [VALUE_W-1:0] pick_search_key();
        int unsigned               sel;
        logic signed [VALUE_W-1:0] base;
        begin
            sel = $urandom_range(0, 99);
            if (planned_count == 0 || sel >= 85) return $urandom();
            base = planned_vals[$urandom_range(0, planned_count - 1)];
            if (sel < 50) return base;
            if (sel < 60) return base + 1;
            if (sel < 70) return base - 1;
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
    endfunction

    // Build the whole command list up front: directed corner cases, then random traffic.
    initial begin
        int unsigned n;
        burst_left    = 0;
        planned_count = 0;

        // Empty store: every search misses.
        add_cmd(CMD_SEARCH, '0);
        add_cmd(CMD_SEARCH, VAL_MIN);
        add_cmd(CMD_SEARCH, VAL_MAX);
        // First entry at the bottom of the range, then hit and miss around it.
        add_cmd(CMD_APPEND, VAL_MIN);
        add_cmd(CMD_SEARCH, VAL_MIN);
        add_cmd(CMD_SEARCH, VAL_MIN + 1);
        add_cmd(CMD_SEARCH, VAL_MAX);
        // Duplicates: the search reports whichever copy it probes first.
        add_cmd(CMD_APPEND, -1000);
        add_cmd(CMD_APPEND, -1000);
        add_cmd(CMD_APPEND, -1000);
        add_cmd(CMD_SEARCH, -1000);
        add_cmd(CMD_SEARCH, -999);
        add_cmd(CMD_SEARCH, -1001);
        add_cmd(CMD_APPEND, -5);
        add_cmd(CMD_SEARCH, -5);
        add_cmd(CMD_SEARCH, VAL_MIN);
        add_cmd(CMD_SEARCH, '0);
        add_cmd(CMD_SEARCH, 32'sh5555_5555);
        add_cmd(CMD_SEARCH, 32'shAAAA_AAAA);
        planned_top = -5;

        // Random part: append-heavy until the store fills, then searches of a full store
        // plus appends that must be dropped.
        for (n = 0; n < RANDOM_CMDS; n++) begin
            if (planned_count < STORE_DEPTH) begin
                if ($urandom_range(0, 99) < 62) add_cmd(CMD_APPEND, next_append_value());
                else add_cmd(CMD_SEARCH, pick_search_key());
            end else begin
                if ($urandom_range(0, 99) < 15) add_cmd(CMD_APPEND, $urandom());
                else add_cmd(CMD_SEARCH, pick_search_key());
            end
        end
    end

    // Reset: held low from time zero, released once.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: present one command at a time, hold it until it transfers, then idle for
    // the next command's gap. start stays high across back-to-back transfers.
    always @(posedge i_clk) begin
        t_store_cmd item;
        if (!i_rst_n) begin
            start        <= 1'b0;
            gap_left     <= 0;
            shadow_count = 0;
        end else if (start && !busy) begin
            predict_store_op(i_cmd, i_item_value);
            if (pending_cmds.size() > 0 && pending_cmds[0].gap == 0) begin
                item = pending_cmds.pop_front();
                i_cmd        <= item.cmd;
                i_item_value <= item.value;
            end else begin
                start <= 1'b0;
                if (pending_cmds.size() > 0) gap_left <= pending_cmds[0].gap - 1;
                else gap_left <= 0;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_cmds.size() > 0) begin
                item = pending_cmds.pop_front();
                start        <= 1'b1;
                i_cmd        <= item.cmd;
                i_item_value <= item.value;
            end
        end
    end

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, exp_val,
                     act_val);
            error_count++;
        end
    endtask

    // Monitor: every strobe must match the oldest expectation, field by field.
    always @(posedge i_clk) begin
        t_store_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, %s %0d pos %0d held %0d",
                         $realtime, "actual status", o_status, o_position,
                         o_entries_held);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                check_field("status", exp_res.status, o_status);
                check_field("position", exp_res.position, o_position);
                check_field("entries_held", exp_res.held, o_entries_held);
                case (exp_res.status)
                    ST_APPENDED: n_appended++;
                    ST_FULL:     n_dropped++;
                    ST_FOUND:    n_found++;
                    default:     n_missed++;
                endcase
            end
        end
    end

    // End of run: all commands transferred, all results in, then a short drain.
    initial begin
        int waited;
        error_count = 0;
        n_appended  = 0;
        n_dropped   = 0;
        n_found     = 0;
        n_missed    = 0;
        wait (i_rst_n === 1'b1);
        while (pending_cmds.size() > 0 || start) @(posedge i_clk);
        waited = 0;
        while (pending_results.size() > 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_results.size() > 0) begin
            $display("%0t: %0d results never arrived: expected 0 outstanding, actual %0d",
                     $realtime, pending_results.size(), pending_results.size());
            error_count += pending_results.size();
        end
        $display("Covered %0d appends (%0d dropped on a full store) and %0d searches",
                 n_appended + n_dropped, n_dropped, n_found + n_missed);
        $display("Searches: %0d hits, %0d misses; %0d mismatches", n_found, n_missed,
                 error_count);
        if (error_count == 0) begin
            $display("** sorted_store_binary_search: PASSED **");
        end else begin
            $display("** sorted_store_binary_search: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #200000;
        $display("** sorted_store_binary_search: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sssb_pkg.sv
rtl/sorted_store_binary_search.sv
bench/sorted_store_binary_search_test.sv
